// ===== rtl/core/bmsm_pkg.sv =====
// Shared types, widths and constants for the binned mean / std-dev merge unit.
package bmsm_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int MAX_SRC_DEF = 16;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 24;
  localparam int ERR_W  = 23;
  localparam int CNT_W  = 5;
  localparam int SUM_W  = 29;
  localparam int SQ_W   = 52;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DIV_W  = 56;
  localparam int DEN_W  = 10;
  localparam int ROOT_W = DIV_W / 2;
  localparam int NQ     = 3;

  localparam logic [CNT_W-1:0] QMIN_RESET    = CNT_W'(3);
  localparam logic [2:0]       ADDR_QMIN     = 3'd0;
  localparam logic             OP_ADD        = 1'b0;
  localparam logic             OP_DRAIN      = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [KEY_W-1:0]        cell_index;
    logic signed [VAL_W-1:0] vel_value;
    logic [ERR_W-1:0]        vel_error;
    logic signed [VAL_W-1:0] pwr_value;
    logic [ERR_W-1:0]        pwr_error;
    logic signed [VAL_W-1:0] wdt_value;
    logic [ERR_W-1:0]        wdt_error;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key_out;
    logic signed [VAL_W-1:0] vel_mean;
    logic [ERR_W-1:0]        vel_spread;
    logic signed [VAL_W-1:0] pwr_mean;
    logic [ERR_W-1:0]        pwr_spread;
    logic signed [VAL_W-1:0] wdt_mean;
    logic [ERR_W-1:0]        wdt_spread;
    logic [CNT_W-1:0]        sample_count;
    logic                    quality_good;
    logic                    overflow_seen;
    logic                    last_entry;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic [CNT_W-1:0]           cnt;
    logic [NQ-1:0][SUM_W-1:0]   sum;
    logic [NQ-1:0][SQ_W-1:0]    sq;
    logic [NQ-1:0][ERR_W-1:0]   err;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic [NQ-1:0][VAL_W-1:0]   val;
    logic [NQ-1:0][SQ_W-1:0]    sq;
    logic [NQ-1:0][ERR_W-1:0]   err;
  } sample_t;

  typedef struct packed {
    logic accum;
    logic create;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_UPD, S_LOAD, S_MGO, S_MWAIT, S_VMUL, S_VSUB,
    S_VGO, S_VWAIT, S_RGO, S_RWAIT, S_OUT
  } state_e;

endpackage

// ===== rtl/core/bmsm_cell.sv =====
// One table entry of the accumulator chain; shifts toward the head on drain.
module bmsm_cell #(
  parameter int CntCap = 16
) (
  input  logic                clk_i,
  input  bmsm_pkg::cell_ctl_t ctl_i,
  input  bmsm_pkg::sample_t   smp_i,
  input  bmsm_pkg::entry_t    next_i,
  input  logic                live_i,
  output logic                hit_o,
  output bmsm_pkg::entry_t    ent_o
);
  import bmsm_pkg::*;

  entry_t ent_q, ent_d;
  logic   room;

  assign room  = ent_q.cnt < CNT_W'(CntCap);
  assign hit_o = live_i && (ent_q.key == smp_i.key);
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.shift) begin
      ent_d = next_i;
    end else if (ctl_i.create) begin
      ent_d.key = smp_i.key;
      ent_d.cnt = CNT_W'(1);
      for (int k = 0; k < NQ; k++) begin
        ent_d.sum[k] = {{(SUM_W-VAL_W){smp_i.val[k][VAL_W-1]}}, smp_i.val[k]};
        ent_d.sq[k]  = smp_i.sq[k];
        ent_d.err[k] = smp_i.err[k];
      end
    end else if (ctl_i.accum && room) begin
      ent_d.cnt = ent_q.cnt + CNT_W'(1);
      for (int k = 0; k < NQ; k++) begin
        ent_d.sum[k] = ent_q.sum[k] +
                       {{(SUM_W-VAL_W){smp_i.val[k][VAL_W-1]}}, smp_i.val[k]};
        ent_d.sq[k]  = ent_q.sq[k] + smp_i.sq[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== rtl/core/bmsm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bmsm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bmsm_pkg::DIV_W-1:0] dividend_i,
  input  logic [bmsm_pkg::DEN_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [bmsm_pkg::DIV_W-1:0] quot_o
);
  import bmsm_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, dvs_q;
  logic [DEN_W:0]   shifted, diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/bmsm_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module bmsm_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bmsm_pkg::DIV_W-1:0]  rad_i,
  output logic                        done_o,
  output logic [bmsm_pkg::ROOT_W-1:0] root_o
);
  import bmsm_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [DIV_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W+2:0] rem_sh, trial, diff;
  logic              ge;

  assign rem_sh = {rem_q, rad_q[DIV_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[DIV_W-3:0], 2'b00};
      rem_q  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/binned_mean_stddev_merge_unit.sv =====
// Top level: keyed accumulator chain with serial mean / std-dev drain engine.
// An add transaction passes through capture, square and chain update; one item at a time.
// A drain takes per entry a load state, an output state and per quantity a mean divide
// (start, then wait); with two or more samples add the product and subtract states, a
// variance divide and a root, all on the shared divider and square-root units.
// Reset is asynchronous active low: empty table, overflow clear, threshold 3; no sweep.
module binned_mean_stddev_merge_unit #(
  parameter int TABLE_DEPTH = bmsm_pkg::DEPTH_DEF,
  parameter int MAX_SOURCES = bmsm_pkg::MAX_SRC_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bmsm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bmsm_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import bmsm_pkg::*;

  localparam int FillW  = $clog2(TABLE_DEPTH + 1);
  localparam int CntCap = (MAX_SOURCES < 31) ? MAX_SOURCES : 31;

  state_e            state_q, state_d;
  in_t               in_q;
  sample_t           bc_q;
  entry_t            ent_q;
  out_t              out_q;
  logic              out_valid_q;
  logic [FillW-1:0]  fill_q, left_q;
  logic              ovf_q, dovf_q;
  logic [CNT_W-1:0]  qmin_q;
  logic [1:0]        q_q;
  logic [NQ-1:0][VAL_W-1:0] mean_q;
  logic [NQ-1:0][ERR_W-1:0] spread_q;
  logic [DIV_W-1:0]  s1sq_q, ns2_q, num_q;

  logic              in_acc, div_start, div_done, sqrt_start, sqrt_done, out_load;
  logic              any_hit, single, last_q, cfg_wr;
  logic [DIV_W-1:0]  div_dvd, div_quot;
  logic [DEN_W-1:0]  div_dvs, den;
  logic [ROOT_W-1:0] root;
  logic [SUM_W-1:0]  s1, s1_abs;
  logic              s1_neg;
  logic [NQ-1:0][VAL_W-1:0]  in_vals;
  logic signed [2*VAL_W-1:0] prod [NQ];

  logic [TABLE_DEPTH-1:0] hit_vec;
  entry_t                 ents [TABLE_DEPTH];

  // chain of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nxt;
    assign ctl.shift  = (state_q == S_LOAD);
    assign ctl.create = (state_q == S_UPD) && !any_hit && (fill_q == FillW'(i));
    assign ctl.accum  = (state_q == S_UPD) && hit_vec[i];
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nxt = ents[i];
    end else begin : g_mid
      assign nxt = ents[i+1];
    end
    bmsm_cell #(.CntCap(CntCap)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .smp_i  (bc_q),
      .next_i (nxt),
      .live_i (FillW'(i) < fill_q),
      .hit_o  (hit_vec[i]),
      .ent_o  (ents[i])
    );
  end

  assign any_hit = |hit_vec;

  bmsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  bmsm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // per-quantity operand selection
  assign s1     = ent_q.sum[q_q];
  assign s1_neg = s1[SUM_W-1];
  assign s1_abs = s1_neg ? (~s1 + SUM_W'(1)) : s1;
  assign single = ent_q.cnt <= CNT_W'(1);
  assign last_q = (q_q == 2'd2);
  assign den    = DEN_W'(ent_q.cnt) * (DEN_W'(ent_q.cnt) - DEN_W'(1));
  assign div_dvd = (state_q == S_MGO) ? DIV_W'(s1_abs[MAG_W-1:0]) : num_q;
  assign div_dvs = (state_q == S_MGO) ? DEN_W'(ent_q.cnt) : den;

  assign in_vals = {in_q.wdt_value, in_q.pwr_value, in_q.vel_value};

  for (genvar k = 0; k < NQ; k++) begin : g_sq
    assign prod[k] = $signed(in_vals[k]) * $signed(in_vals[k]);
  end

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && (paddr == ADDR_QMIN);
  assign prdata      = (paddr == ADDR_QMIN) ? 32'(qmin_q) : 32'd0;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.op == OP_DRAIN) begin
            state_d = (fill_q != '0) ? S_LOAD : S_IDLE;
          end else begin
            state_d = S_SQ;
          end
        end
      end
      S_SQ:   state_d = S_UPD;
      S_UPD:  state_d = S_IDLE;
      S_LOAD: state_d = S_MGO;
      S_MGO: begin
        div_start = 1'b1;
        state_d   = S_MWAIT;
      end
      S_MWAIT: begin
        if (div_done) begin
          if (!single)     state_d = S_VMUL;
          else if (last_q) state_d = S_OUT;
          else             state_d = S_MGO;
        end
      end
      S_VMUL: state_d = S_VSUB;
      S_VSUB: state_d = S_VGO;
      S_VGO: begin
        div_start = 1'b1;
        state_d   = S_VWAIT;
      end
      S_VWAIT: if (div_done) state_d = S_RGO;
      S_RGO: begin
        sqrt_start = 1'b1;
        state_d    = S_RWAIT;
      end
      S_RWAIT: if (sqrt_done) state_d = last_q ? S_OUT : S_MGO;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = (left_q == FillW'(1)) ? S_IDLE : S_LOAD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      left_q      <= '0;
      ovf_q       <= 1'b0;
      dovf_q      <= 1'b0;
      out_valid_q <= 1'b0;
      qmin_q      <= QMIN_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_wr) qmin_q <= pwdata[CNT_W-1:0];
      if (in_acc && in_data_i.op == OP_DRAIN) begin
        if (fill_q == '0) begin
          ovf_q <= 1'b0;
        end else begin
          left_q <= fill_q;
          dovf_q <= ovf_q;
        end
      end
      if (state_q == S_UPD && !any_hit) begin
        if (fill_q < FillW'(TABLE_DEPTH)) fill_q <= fill_q + FillW'(1);
        else                              ovf_q  <= 1'b1;
      end
      if (out_load) begin
        left_q <= left_q - FillW'(1);
        if (left_q == FillW'(1)) begin
          fill_q <= '0;
          ovf_q  <= 1'b0;
        end
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
    if (state_q == S_SQ) begin
      bc_q.key <= in_q.cell_index;
      bc_q.val <= {in_q.wdt_value, in_q.pwr_value, in_q.vel_value};
      bc_q.err <= {in_q.wdt_error, in_q.pwr_error, in_q.vel_error};
      for (int k = 0; k < NQ; k++) begin
        bc_q.sq[k] <= SQ_W'(prod[k][2*VAL_W-2:0]);
      end
    end
    if (state_q == S_LOAD) begin
      ent_q <= ents[0];
      q_q   <= 2'd0;
    end
    if (state_q == S_MWAIT && div_done) begin
      mean_q[q_q] <= s1_neg ? (VAL_W'(0) - div_quot[VAL_W-1:0]) : div_quot[VAL_W-1:0];
      if (single) begin
        spread_q[q_q] <= ent_q.err[q_q];
        if (!last_q) q_q <= q_q + 2'd1;
      end
    end
    if (state_q == S_VMUL) begin
      s1sq_q <= DIV_W'(s1_abs[MAG_W-1:0]) * DIV_W'(s1_abs[MAG_W-1:0]);
      ns2_q  <= DIV_W'(ent_q.cnt) * DIV_W'(ent_q.sq[q_q]);
    end
    if (state_q == S_VSUB) begin
      num_q <= (ns2_q > s1sq_q) ? (ns2_q - s1sq_q) : '0;
    end
    if (state_q == S_RWAIT && sqrt_done) begin
      spread_q[q_q] <= (root[ROOT_W-1:ERR_W] != '0) ? {ERR_W{1'b1}} : root[ERR_W-1:0];
      if (!last_q) q_q <= q_q + 2'd1;
    end
    if (out_load) begin
      out_q.key_out       <= ent_q.key;
      out_q.vel_mean      <= mean_q[0];
      out_q.vel_spread    <= spread_q[0];
      out_q.pwr_mean      <= mean_q[1];
      out_q.pwr_spread    <= spread_q[1];
      out_q.wdt_mean      <= mean_q[2];
      out_q.wdt_spread    <= spread_q[2];
      out_q.sample_count  <= ent_q.cnt;
      out_q.quality_good  <= ent_q.cnt >= qmin_q;
      out_q.overflow_seen <= dovf_q;
      out_q.last_entry    <= (left_q == FillW'(1));
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(TABLE_DEPTH)) else $error("fill level beyond table depth");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec)) else $error("key present in more than one cell");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_load && left_q == FillW'(1)) |=> (fill_q == '0 && !ovf_q))
    else $error("table not cleared after drain");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done) else $error("divider done right after start");

endmodule
